>>> hdl/dtq_pkg.sv
// shared types, constants and helpers of the deadline timer queue
`default_nettype none

package dtq_pkg;

    // field widths
    localparam int CMD_W   = 3;
    localparam int ID_W    = 4;
    localparam int DELAY_W = 16;
    localparam int TIME_W  = 32;

    // timer table size and scan index width
    localparam int NUM_TIMERS = 16;
    localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // most timers fired by one tick
    localparam int MAX_FIRES  = 16;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

    // queue depths
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // command codes on the input
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_KICK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    // status codes
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    // classified operation
    typedef enum logic [2:0] {
        OP_ADD,
        OP_DEL,
        OP_MOD,
        OP_KICK,
        OP_TICK,
        OP_BAD
    } t_op;

    // classified command item
    typedef struct packed {
        t_op                op;
        logic [TIDX_W-1:0]  idx;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  now;
    } t_cmd;

    // result item
    typedef struct packed {
        logic            fired_valid;
        logic [ID_W-1:0] fired_id;
        logic            status;
        logic            last;
    } t_res;

    // back end states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEL,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    // now plus delay, saturating at the top of the time range
    function automatic logic [TIME_W-1:0] arm_time(input logic [TIME_W-1:0] now,
                                                   input logic [DELAY_W-1:0] d);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, d};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/dtq_cmd_queue.sv
// two-entry queue of classified commands between front and back
`default_nettype none

module dtq_cmd_queue (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire dtq_pkg::t_cmd i_item,
    output logic         o_full,
    input  wire          i_pop,
    output dtq_pkg::t_cmd o_head,
    output logic         o_empty
);

    dtq_pkg::t_cmd                r_mem [dtq_pkg::Q_DEPTH];
    logic [dtq_pkg::Q_PTR_W-1:0] r_wptr;
    logic [dtq_pkg::Q_PTR_W-1:0] r_rptr;
    logic [dtq_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    // handshake
    assign o_full  = (r_cnt == dtq_pkg::Q_CNT_W'(dtq_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/dtq_front.sv
// front end: accepts items, classifies them and queues them for the back end
`default_nettype none

module dtq_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    output logic                        o_full,
    input  wire  [dtq_pkg::CMD_W-1:0]   i_cmd,
    input  wire  [dtq_pkg::ID_W-1:0]    i_timer_id,
    input  wire  [dtq_pkg::DELAY_W-1:0] i_delay,
    input  wire  [dtq_pkg::TIME_W-1:0]  i_now,
    input  wire                         i_pop,
    output dtq_pkg::t_cmd               o_head,
    output logic                        o_empty
);

    dtq_pkg::t_op  op_raw;
    dtq_pkg::t_cmd item;
    logic          id_ok;
    logic          q_full;

    // decode command code
    always_comb begin
        case (i_cmd)
            dtq_pkg::CMD_ADD:    op_raw = dtq_pkg::OP_ADD;
            dtq_pkg::CMD_DELETE: op_raw = dtq_pkg::OP_DEL;
            dtq_pkg::CMD_MODIFY: op_raw = dtq_pkg::OP_MOD;
            dtq_pkg::CMD_KICK:   op_raw = dtq_pkg::OP_KICK;
            dtq_pkg::CMD_TICK:   op_raw = dtq_pkg::OP_TICK;
            default:             op_raw = dtq_pkg::OP_BAD;
        endcase
    end

    // out-of-range ids turn addressed commands into ignored ones
    assign id_ok = (32'(i_timer_id) < 32'(dtq_pkg::NUM_TIMERS));

    always_comb begin
        item.op    = op_raw;
        item.idx   = dtq_pkg::TIDX_W'(i_timer_id);
        item.delay = i_delay;
        item.now   = i_now;
        if (!id_ok && op_raw != dtq_pkg::OP_TICK) begin
            item.op = dtq_pkg::OP_BAD;
        end
    end

    assign o_full = q_full;

    // command queue toward the back end
    dtq_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !q_full),
        .i_item  (item),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_head  (o_head),
        .o_empty (o_empty)
    );

endmodule

`default_nettype wire

>>> hdl/dtq_back.sv
// back end: timer table, expiry scan and result queue
`default_nettype none

module dtq_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire dtq_pkg::t_cmd        i_head,
    input  wire                       i_cmd_empty,
    output logic                      o_cmd_pop,
    output logic                      o_empty,
    input  wire                       i_pop,
    output dtq_pkg::t_res             o_res
);

    localparam logic [dtq_pkg::TIDX_W-1:0] LAST_IDX =
        dtq_pkg::TIDX_W'(dtq_pkg::NUM_TIMERS - 1);
    localparam logic [dtq_pkg::FIRE_CNT_W-1:0] LAST_FIRE =
        dtq_pkg::FIRE_CNT_W'(dtq_pkg::MAX_FIRES - 1);

    // timer table
    logic [dtq_pkg::NUM_TIMERS-1:0] r_active;
    logic [dtq_pkg::NUM_TIMERS-1:0] n_active;
    logic [dtq_pkg::DELAY_W-1:0]    r_delay    [dtq_pkg::NUM_TIMERS];
    logic [dtq_pkg::TIME_W-1:0]     r_deadline [dtq_pkg::NUM_TIMERS];
    logic                           tbl_we_delay;
    logic                           tbl_we_dl;
    logic [dtq_pkg::TIDX_W-1:0]     tbl_widx;
    logic [dtq_pkg::TIME_W-1:0]     tbl_wdl;

    // control state
    dtq_pkg::t_state                r_state;
    dtq_pkg::t_state                n_state;
    dtq_pkg::t_state                r_after;
    dtq_pkg::t_state                n_after;

    // scan state
    logic [dtq_pkg::TIDX_W-1:0]     r_idx;
    logic [dtq_pkg::TIDX_W-1:0]     n_idx;
    logic                           r_found;
    logic                           n_found;
    logic [dtq_pkg::TIDX_W-1:0]     r_best;
    logic [dtq_pkg::TIDX_W-1:0]     n_best;
    logic [dtq_pkg::TIME_W-1:0]     r_best_dl;
    logic [dtq_pkg::TIME_W-1:0]     n_best_dl;
    logic [dtq_pkg::TIME_W-1:0]     r_now;
    logic [dtq_pkg::TIME_W-1:0]     n_now;
    logic                           r_pend;
    logic                           n_pend;
    logic [dtq_pkg::TIDX_W-1:0]     r_pend_id;
    logic [dtq_pkg::TIDX_W-1:0]     n_pend_id;
    logic [dtq_pkg::FIRE_CNT_W-1:0] r_cnt;
    logic [dtq_pkg::FIRE_CNT_W-1:0] n_cnt;
    dtq_pkg::t_res                  r_res;
    dtq_pkg::t_res                  n_res;

    // scan compare
    logic [dtq_pkg::TIME_W-1:0]     scan_dl;
    logic                           hit;
    logic                           better;

    // command execution
    logic                           cmd_act;
    logic [dtq_pkg::DELAY_W-1:0]    arm_delay;
    logic [dtq_pkg::TIME_W-1:0]     arm;

    // result queue
    dtq_pkg::t_res                  r_oq [dtq_pkg::Q_DEPTH];
    logic [dtq_pkg::Q_PTR_W-1:0]    r_owp;
    logic [dtq_pkg::Q_PTR_W-1:0]    r_orp;
    logic [dtq_pkg::Q_CNT_W-1:0]    r_ocnt;
    logic                           o_full_q;
    logic                           res_push;
    logic                           res_pop;

    // expiry test for the entry under the scan index
    assign scan_dl = r_deadline[r_idx];
    assign hit     = r_active[r_idx] && (scan_dl <= r_now);
    assign better  = hit && (!r_found || (scan_dl < r_best_dl));

    // arming time for add, modify and kick
    assign cmd_act   = r_active[i_head.idx];
    assign arm_delay = (i_head.op == dtq_pkg::OP_KICK) ? r_delay[i_head.idx] : i_head.delay;
    assign arm       = dtq_pkg::arm_time(i_head.now, arm_delay);

    // result queue handshake
    assign o_full_q = (r_ocnt == dtq_pkg::Q_CNT_W'(dtq_pkg::Q_DEPTH));
    assign o_empty  = (r_ocnt == '0);
    assign res_push = (r_state == dtq_pkg::ST_EMIT) && !o_full_q;
    assign res_pop  = i_pop && !o_empty;
    assign o_res    = r_oq[r_orp];

    // next state
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        case (r_state)
            dtq_pkg::ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_head.op == dtq_pkg::OP_TICK) begin
                        n_state = dtq_pkg::ST_SCAN;
                    end else begin
                        n_state = dtq_pkg::ST_EMIT;
                        n_after = dtq_pkg::ST_IDLE;
                    end
                end
            end
            dtq_pkg::ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = dtq_pkg::ST_SEL;
                end
            end
            dtq_pkg::ST_SEL: begin
                if (!r_found) begin
                    n_state = dtq_pkg::ST_EMIT;
                    n_after = dtq_pkg::ST_IDLE;
                end else if (r_pend) begin
                    n_state = dtq_pkg::ST_EMIT;
                    n_after = (r_cnt == LAST_FIRE) ? dtq_pkg::ST_FLUSH : dtq_pkg::ST_SCAN;
                end else begin
                    n_state = (r_cnt == LAST_FIRE) ? dtq_pkg::ST_FLUSH : dtq_pkg::ST_SCAN;
                end
            end
            dtq_pkg::ST_EMIT: begin
                if (!o_full_q) begin
                    n_state = r_after;
                end
            end
            dtq_pkg::ST_FLUSH: begin
                n_state = dtq_pkg::ST_EMIT;
                n_after = dtq_pkg::ST_IDLE;
            end
            default: begin
                n_state = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and table updates
    always_comb begin
        o_cmd_pop    = 1'b0;
        n_active     = r_active;
        tbl_we_delay = 1'b0;
        tbl_we_dl    = 1'b0;
        tbl_widx     = i_head.idx;
        tbl_wdl      = arm;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_best_dl    = r_best_dl;
        n_now        = r_now;
        n_pend       = r_pend;
        n_pend_id    = r_pend_id;
        n_cnt        = r_cnt;
        n_res        = r_res;
        case (r_state)
            dtq_pkg::ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop         = 1'b1;
                    n_res.fired_valid = 1'b0;
                    n_res.fired_id    = '0;
                    n_res.status      = dtq_pkg::STATUS_DONE;
                    n_res.last        = 1'b1;
                    case (i_head.op)
                        dtq_pkg::OP_TICK: begin
                            n_idx   = '0;
                            n_found = 1'b0;
                            n_now   = i_head.now;
                            n_pend  = 1'b0;
                            n_cnt   = '0;
                        end
                        dtq_pkg::OP_ADD: begin
                            tbl_we_delay          = 1'b1;
                            tbl_we_dl             = 1'b1;
                            n_active[i_head.idx]  = 1'b1;
                        end
                        dtq_pkg::OP_DEL: begin
                            if (cmd_act) begin
                                n_active[i_head.idx] = 1'b0;
                            end else begin
                                n_res.status = dtq_pkg::STATUS_IGNORED;
                            end
                        end
                        dtq_pkg::OP_MOD: begin
                            if (cmd_act) begin
                                tbl_we_delay = 1'b1;
                                tbl_we_dl    = 1'b1;
                            end else begin
                                n_res.status = dtq_pkg::STATUS_IGNORED;
                            end
                        end
                        dtq_pkg::OP_KICK: begin
                            if (cmd_act) begin
                                tbl_we_dl = 1'b1;
                            end else begin
                                n_res.status = dtq_pkg::STATUS_IGNORED;
                            end
                        end
                        default: begin
                            n_res.status = dtq_pkg::STATUS_IGNORED;
                        end
                    endcase
                end
            end
            dtq_pkg::ST_SCAN: begin
                // one entry per cycle through the shared comparator
                if (better) begin
                    n_found   = 1'b1;
                    n_best    = r_idx;
                    n_best_dl = scan_dl;
                end
                n_idx = r_idx + 1'b1;
            end
            dtq_pkg::ST_SEL: begin
                n_idx   = '0;
                n_found = 1'b0;
                if (r_found) begin
                    // fire the earliest, hold it until we know whether it is the last
                    n_active[r_best]  = 1'b0;
                    n_cnt             = r_cnt + 1'b1;
                    n_pend            = 1'b1;
                    n_pend_id         = r_best;
                    n_res.fired_valid = 1'b1;
                    n_res.fired_id    = dtq_pkg::ID_W'(r_pend_id);
                    n_res.status      = dtq_pkg::STATUS_DONE;
                    n_res.last        = 1'b0;
                end else begin
                    n_res.fired_valid = r_pend;
                    n_res.fired_id    = r_pend ? dtq_pkg::ID_W'(r_pend_id) : '0;
                    n_res.status      = dtq_pkg::STATUS_DONE;
                    n_res.last        = 1'b1;
                end
            end
            dtq_pkg::ST_FLUSH: begin
                n_res.fired_valid = 1'b1;
                n_res.fired_id    = dtq_pkg::ID_W'(r_pend_id);
                n_res.status      = dtq_pkg::STATUS_DONE;
                n_res.last        = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dtq_pkg::ST_IDLE;
            r_after  <= dtq_pkg::ST_IDLE;
            r_active <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_active <= n_active;
            r_pend   <= n_pend;
            r_found  <= n_found;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_best    <= n_best;
        r_best_dl <= n_best_dl;
        r_now     <= n_now;
        r_pend_id <= n_pend_id;
        r_res     <= n_res;
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (tbl_we_delay) begin
            r_delay[tbl_widx] <= i_head.delay;
        end
        if (tbl_we_dl) begin
            r_deadline[tbl_widx] <= tbl_wdl;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owp] <= r_res;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (res_push) begin
                r_owp <= r_owp + 1'b1;
            end
            if (res_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            if (res_push && !res_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (res_pop && !res_push) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/deadline_timer_queue_core.sv
// top level of the deadline timer queue
//
// A table of sixteen one-shot timers driven by add, delete, modify, kick and
// tick items; every item gives one result, except a tick, which gives one
// result per fired timer in deadline order (ties to the lower id), the last
// one flagged, or a single result if no timer fires. A two-entry item queue
// separates the classifying front end from the executing back end, and a
// two-entry result queue separates the back end from the consumer. A tick
// searches the table once per fired timer, plus one final search that finds
// nothing unless MAX_FIRES timers have fired, and each search walks all
// NUM_TIMERS entries through a single deadline comparator.
`default_nettype none

module deadline_timer_queue_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    output logic                        o_full,
    input  wire  [dtq_pkg::CMD_W-1:0]   i_cmd,
    input  wire  [dtq_pkg::ID_W-1:0]    i_timer_id,
    input  wire  [dtq_pkg::DELAY_W-1:0] i_delay,
    input  wire  [dtq_pkg::TIME_W-1:0]  i_now,
    output logic                        o_empty,
    input  wire                         i_pop,
    output logic                        o_fired_valid,
    output logic [dtq_pkg::ID_W-1:0]    o_fired_id,
    output logic                        o_status,
    output logic                        o_last
);

    dtq_pkg::t_cmd head;
    logic          cmd_empty;
    logic          cmd_pop;
    dtq_pkg::t_res res;

    // accept and classify items
    dtq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_cmd      (i_cmd),
        .i_timer_id (i_timer_id),
        .i_delay    (i_delay),
        .i_now      (i_now),
        .i_pop      (cmd_pop),
        .o_head     (head),
        .o_empty    (cmd_empty)
    );

    // execute commands and scan for expired timers
    dtq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_res       (res)
    );

    // result fields
    assign o_fired_valid = res.fired_valid;
    assign o_fired_id    = res.fired_id;
    assign o_status      = res.status;
    assign o_last        = res.last;

endmodule

`default_nettype wire

>>> bench/deadline_timer_queue_core_tb.sv
`timescale 1ns / 100ps
// testbench of the deadline timer queue core: directed and random items, checked by a predictor
`default_nettype none

module deadline_timer_queue_core_tb;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 4;
    localparam int LIMIT_NS    = 20_000_000;
    // a tick firing every timer keeps the back end busy this long
    localparam int TAIL_CYCLES =
        (dtq_pkg::MAX_FIRES + 1) * (dtq_pkg::NUM_TIMERS + 2) + 50;
    localparam int RANDOM_PER_PHASE = 20;

    localparam logic [dtq_pkg::CMD_W-1:0]  CMD_RSV_FIRST = dtq_pkg::CMD_TICK + 1'b1;
    localparam logic [dtq_pkg::CMD_W-1:0]  CMD_RSV_LAST  = '1;
    localparam logic [dtq_pkg::TIME_W-1:0] TIME_TOP      = '1;

    typedef struct {
        logic [dtq_pkg::CMD_W-1:0]   cmd;
        logic [dtq_pkg::ID_W-1:0]    id;
        logic [dtq_pkg::DELAY_W-1:0] delay;
        logic [dtq_pkg::TIME_W-1:0]  now;
    } t_timer_cmd;

    // clock, reset and block ports
    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_push     = 1'b0;
    logic                          i_pop      = 1'b0;
    logic [dtq_pkg::CMD_W-1:0]     i_cmd      = '0;
    logic [dtq_pkg::ID_W-1:0]      i_timer_id = '0;
    logic [dtq_pkg::DELAY_W-1:0]   i_delay    = '0;
    logic [dtq_pkg::TIME_W-1:0]    i_now      = '0;
    logic                          o_full;
    logic                          o_empty;
    logic                          o_fired_valid;
    logic [dtq_pkg::ID_W-1:0]      o_fired_id;
    logic                          o_status;
    logic                          o_last;

    // stimulus and expectation stores
    t_timer_cmd    pending_cmds[$];
    dtq_pkg::t_res expected_results[$];
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            fail_count     = 0;
    logic [dtq_pkg::TIME_W-1:0] wall_now = '0;

    // predictor copy of the timer table
    logic                        armed[dtq_pkg::NUM_TIMERS];
    logic [dtq_pkg::DELAY_W-1:0] saved_delay[dtq_pkg::NUM_TIMERS];
    logic [dtq_pkg::TIME_W-1:0]  due_time[dtq_pkg::NUM_TIMERS];

    always #CLK_HALF i_clk = ~i_clk;

    deadline_timer_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_cmd         (i_cmd),
        .i_timer_id    (i_timer_id),
        .i_delay       (i_delay),
        .i_now         (i_now),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_fired_valid (o_fired_valid),
        .o_fired_id    (o_fired_id),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // now plus delay, clamped at the top of the time range
    function automatic logic [dtq_pkg::TIME_W-1:0] deadline_of(
        input logic [dtq_pkg::TIME_W-1:0] now,
        input logic [dtq_pkg::DELAY_W-1:0] d);
        if (TIME_TOP - now < {{(dtq_pkg::TIME_W - dtq_pkg::DELAY_W){1'b0}}, d}) begin
            return TIME_TOP;
        end
        return now + d;
    endfunction

    // random id and delay fields
    function automatic logic [dtq_pkg::ID_W-1:0] rand_id();
        return dtq_pkg::ID_W'($urandom());
    endfunction

    function automatic logic [dtq_pkg::DELAY_W-1:0] rand_delay(input int lo, input int hi);
        return dtq_pkg::DELAY_W'($urandom_range(lo, hi));
    endfunction

    // apply one accepted item to the timer table and queue its results
    task automatic predict_timer_cmd(input t_timer_cmd c);
        dtq_pkg::t_res fires[$];
        dtq_pkg::t_res r;
        int            best;
        logic          st;
        r  = '0;
        st = dtq_pkg::STATUS_DONE;
        if (c.cmd == dtq_pkg::CMD_TICK) begin
            // earliest deadline first, lower id wins a tie
            while (fires.size() < dtq_pkg::MAX_FIRES) begin
                best = -1;
                for (int i = 0; i < dtq_pkg::NUM_TIMERS; i++) begin
                    if (armed[i] && due_time[i] <= c.now &&
                        (best < 0 || due_time[i] < due_time[best])) begin
                        best = i;
                    end
                end
                if (best < 0) break;
                armed[best]   = 1'b0;
                r             = '0;
                r.fired_valid = 1'b1;
                r.fired_id    = best[dtq_pkg::ID_W-1:0];
                r.status      = dtq_pkg::STATUS_DONE;
                fires.push_back(r);
            end
            if (fires.size() == 0) begin
                r = '0;
            end else begin
                r = fires.pop_back();
            end
            r.last = 1'b1;
            fires.push_back(r);
            foreach (fires[k]) expected_results.push_back(fires[k]);
        end else begin
            if (c.cmd > dtq_pkg::CMD_TICK || c.id >= dtq_pkg::NUM_TIMERS) begin
                st = dtq_pkg::STATUS_IGNORED;
            end else if (c.cmd == dtq_pkg::CMD_ADD) begin
                saved_delay[c.id] = c.delay;
                due_time[c.id]    = deadline_of(c.now, c.delay);
                armed[c.id]       = 1'b1;
            end else if (!armed[c.id]) begin
                st = dtq_pkg::STATUS_IGNORED;
            end else if (c.cmd == dtq_pkg::CMD_DELETE) begin
                armed[c.id] = 1'b0;
            end else if (c.cmd == dtq_pkg::CMD_MODIFY) begin
                saved_delay[c.id] = c.delay;
                due_time[c.id]    = deadline_of(c.now, c.delay);
            end else begin
                due_time[c.id] = deadline_of(c.now, saved_delay[c.id]);
            end
            r        = '0;
            r.status = st;
            r.last   = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // item driver: predicts each item as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                predict_timer_cmd('{i_cmd, i_timer_id, i_delay, i_now});
                pending_cmds.delete(0);
            end
            if (!i_push || !o_full) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_push     <= 1'b1;
                    i_cmd      <= pending_cmds[0].cmd;
                    i_timer_id <= pending_cmds[0].id;
                    i_delay    <= pending_cmds[0].delay;
                    i_now      <= pending_cmds[0].now;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    end

    // result monitor with random pop stalls
    always @(posedge i_clk) begin : result_check
        dtq_pkg::t_res want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: fired_valid %0b fired_id %0d status %0b last %0b",
                           o_fired_valid, o_fired_id, o_status, o_last);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("fired_valid", int'(want.fired_valid), int'(o_fired_valid));
                    check_field("fired_id", int'(want.fired_id), int'(o_fired_id));
                    check_field("status", int'(want.status), int'(o_status));
                    check_field("last", int'(want.last), int'(o_last));
                end
            end
            i_pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_cmd(input logic [dtq_pkg::CMD_W-1:0] cmd,
                            input logic [dtq_pkg::ID_W-1:0] id,
                            input logic [dtq_pkg::DELAY_W-1:0] d,
                            input logic [dtq_pkg::TIME_W-1:0] now);
        t_timer_cmd c;
        c.cmd   = cmd;
        c.id    = id;
        c.delay = d;
        c.now   = now;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
    endtask

    // time mostly creeps forward, now and then it jumps anywhere or near the top
    task automatic advance_wall();
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            wall_now = $urandom();
        end else if (r < 8) begin
            wall_now = TIME_TOP - $urandom_range(0, 300);
        end else begin
            wall_now = deadline_of(wall_now, rand_delay(0, 40));
        end
    endtask

    function automatic logic [dtq_pkg::DELAY_W-1:0] pick_delay();
        if ($urandom_range(99) < 12) return dtq_pkg::DELAY_W'($urandom());
        return rand_delay(0, 60);
    endfunction

    // random mix of commands and ticks, with bursts of arms followed by a tick
    task automatic queue_random(input int count);
        int made;
        int r;
        int n_arm;
        int j;
        int tmp;
        int ids[dtq_pkg::NUM_TIMERS];
        made = 0;
        while (made < count) begin
            advance_wall();
            r = $urandom_range(99);
            if (r < 12) begin
                n_arm = ($urandom_range(99) < 30) ? dtq_pkg::NUM_TIMERS :
                        $urandom_range(2, dtq_pkg::NUM_TIMERS);
                for (int i = 0; i < dtq_pkg::NUM_TIMERS; i++) ids[i] = i;
                for (int i = dtq_pkg::NUM_TIMERS - 1; i > 0; i--) begin
                    j      = $urandom_range(0, i);
                    tmp    = ids[i];
                    ids[i] = ids[j];
                    ids[j] = tmp;
                end
                for (int i = 0; i < n_arm; i++) begin
                    push_cmd(dtq_pkg::CMD_ADD, ids[i][dtq_pkg::ID_W-1:0], rand_delay(0, 6),
                             wall_now);
                end
                wall_now = deadline_of(wall_now, rand_delay(6, 12));
                push_cmd(dtq_pkg::CMD_TICK, rand_id(), rand_delay(0, 65535), wall_now);
                made += n_arm + 1;
            end else begin
                if (r < 37) begin
                    push_cmd(dtq_pkg::CMD_TICK, rand_id(), rand_delay(0, 65535), wall_now);
                end else if (r < 62) begin
                    push_cmd(dtq_pkg::CMD_ADD, rand_id(), pick_delay(), wall_now);
                end else if (r < 72) begin
                    push_cmd(dtq_pkg::CMD_MODIFY, rand_id(), pick_delay(), wall_now);
                end else if (r < 82) begin
                    push_cmd(dtq_pkg::CMD_KICK, rand_id(), rand_delay(0, 65535), wall_now);
                end else if (r < 92) begin
                    push_cmd(dtq_pkg::CMD_DELETE, rand_id(), rand_delay(0, 65535), wall_now);
                end else begin
                    push_cmd(dtq_pkg::CMD_W'($urandom_range(CMD_RSV_FIRST, CMD_RSV_LAST)),
                             rand_id(), rand_delay(0, 65535), wall_now);
                end
                made++;
            end
        end
    endtask

    // timeout
    initial begin
        #LIMIT_NS;
        $display("[deadline_timer_queue_core] ERROR");
        $finish;
    end

    // main sequence
    initial begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 63, 0, 15};
        recv_pct = '{0, 0, 63, 15};
        for (int i = 0; i < dtq_pkg::NUM_TIMERS; i++) begin
            armed[i]       = 1'b0;
            saved_delay[i] = '0;
            due_time[i]    = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tick, commands on idle timers, re-arm, reserved codes
        push_cmd(dtq_pkg::CMD_TICK, 0, 0, 0);
        push_cmd(dtq_pkg::CMD_DELETE, 0, 0, 0);
        push_cmd(dtq_pkg::CMD_MODIFY, 15, 16'hFFFF, 0);
        push_cmd(dtq_pkg::CMD_KICK, 5, 0, 0);
        push_cmd(dtq_pkg::CMD_ADD, 0, 0, 0);
        push_cmd(dtq_pkg::CMD_ADD, 15, 16'hFFFF, 100);
        push_cmd(dtq_pkg::CMD_ADD, 7, 5, 100);
        push_cmd(dtq_pkg::CMD_ADD, 3, 5, 100);
        push_cmd(dtq_pkg::CMD_ADD, 0, 10, 100);
        push_cmd(dtq_pkg::CMD_MODIFY, 15, 0, 200);
        push_cmd(dtq_pkg::CMD_KICK, 7, 0, 150);
        push_cmd(dtq_pkg::CMD_ADD, 9, 5, 150);
        push_cmd(dtq_pkg::CMD_TICK, 0, 0, 105);
        push_cmd(dtq_pkg::CMD_ADD, 4, 3, 150);
        push_cmd(dtq_pkg::CMD_DELETE, 4, 0, 150);
        push_cmd(dtq_pkg::CMD_TICK, 0, 0, 300);
        push_cmd(CMD_RSV_FIRST, 3, 16'h1234, 300);
        push_cmd(CMD_RSV_FIRST + 1'b1, 8, 0, 300);
        push_cmd(CMD_RSV_LAST, 10, 16'h5A5A, 300);
        // deadlines clamped at the top of the time range, where timers 1 and 2 tie
        push_cmd(dtq_pkg::CMD_ADD, 1, 16'hFFFF, 32'hFFFF_FFF0);
        push_cmd(dtq_pkg::CMD_MODIFY, 1, 1, TIME_TOP);
        push_cmd(dtq_pkg::CMD_KICK, 1, 0, TIME_TOP);
        push_cmd(dtq_pkg::CMD_ADD, 2, 0, TIME_TOP);
        push_cmd(dtq_pkg::CMD_TICK, 0, 0, TIME_TOP - 1);
        push_cmd(dtq_pkg::CMD_TICK, 15, 16'hFFFF, TIME_TOP);
        wait_drained();

        // random phases, the sender holds off between them until all results are in
        wall_now = 1000;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            queue_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[deadline_timer_queue_core] OK");
        end else begin
            $display("[deadline_timer_queue_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
